### rtl/core/zhh_pkg.sv
// Shared types, codes and defaults of the zone heating hysteresis table.
package zhh_pkg;

	localparam int MAX_NODES_DEF = 16;
	localparam int SLOT_W        = 4;
	localparam int ZONE_W        = 8;
	localparam int TEMP_W        = 10;
	localparam int CFG_IDX_W     = 1;

	localparam logic [1:0] REQ_REG   = 2'd0;
	localparam logic [1:0] REQ_STATE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_DISC  = 2'd3;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_ON  = 2'd1;
	localparam logic [1:0] MODE_NUM = 2'd2;

	localparam logic KIND_HEATER = 1'b0;

	localparam logic [CFG_IDX_W-1:0] REG_ON_BELOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_ABOVE = 1'd1;

	localparam logic signed [TEMP_W-1:0] ON_BELOW_RST  = 10'sd32;
	localparam logic signed [TEMP_W-1:0] OFF_ABOVE_RST = 10'sd34;

	typedef struct packed {
		logic              kind;
		logic [ZONE_W-1:0] zone;
	} attr_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TEMP_W-1:0] value;
	} stat_t;

	typedef struct packed {
		logic attr_we;
		logic stat_we;
		logic vset;
		logic vclr;
	} tbl_wr_t;

endpackage

### rtl/core/zhh_table.sv
// Entry table: attribute and status memories with flop valid bits.
module zhh_table #(
	parameter int MAX_NODES = zhh_pkg::MAX_NODES_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  zhh_pkg::tbl_wr_t                                    wr,
	input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] wr_idx,
	input  zhh_pkg::attr_t                                      wr_attr,
	input  zhh_pkg::stat_t                                      wr_stat,
	input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] rd_idx,
	input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] chk_idx,
	output zhh_pkg::attr_t                                      rd_attr,
	output zhh_pkg::stat_t                                      rd_stat,
	output logic                                                rd_valid,
	output logic                                                chk_valid
);

	zhh_pkg::attr_t attr_mem [MAX_NODES];
	zhh_pkg::stat_t stat_mem [MAX_NODES];

	logic [MAX_NODES-1:0] valid_q;
	zhh_pkg::attr_t       rd_attr_q;
	zhh_pkg::stat_t       rd_stat_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.attr_we) begin
			attr_mem[wr_idx] <= wr_attr;
		end
		if (wr.stat_we) begin
			stat_mem[wr_idx] <= wr_stat;
		end
		rd_attr_q <= attr_mem[rd_idx];
		rd_stat_q <= stat_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.vset) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (wr.vclr) begin
				valid_q[wr_idx] <= 1'b0;
			end
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd_attr   = rd_attr_q;
	assign rd_stat   = rd_stat_q;
	assign rd_valid  = rd_valid_q;
	assign chk_valid = valid_q[chk_idx];

endmodule

### rtl/core/zhh_seq.sv
// Request decode, table scan sequencer and result register.
module zhh_seq #(
	parameter int MAX_NODES = zhh_pkg::MAX_NODES_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                start,
	input  logic [1:0]                                          req_type,
	input  logic [zhh_pkg::SLOT_W-1:0]                          slot,
	input  logic                                                is_sensor,
	input  logic [zhh_pkg::ZONE_W-1:0]                          area,
	input  logic                                                state_on,
	input  logic signed [zhh_pkg::TEMP_W-1:0]                   reading,
	input  logic signed [zhh_pkg::TEMP_W-1:0]                   on_below,
	input  logic signed [zhh_pkg::TEMP_W-1:0]                   off_above,
	output zhh_pkg::tbl_wr_t                                    wr,
	output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] wr_idx,
	output zhh_pkg::attr_t                                      wr_attr,
	output zhh_pkg::stat_t                                      wr_stat,
	output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] rd_idx,
	output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] chk_idx,
	input  zhh_pkg::attr_t                                      rd_attr,
	input  zhh_pkg::stat_t                                      rd_stat,
	input  logic                                                rd_valid,
	input  logic                                                chk_valid,
	output logic                                                busy,
	output logic                                                strobe,
	output logic [zhh_pkg::SLOT_W-1:0]                          target_slot,
	output logic                                                switch_on,
	output logic                                                last
);

	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ZONE  = 3'd1;
	localparam logic [2:0] ST_ON    = 3'd2;
	localparam logic [2:0] ST_BLK   = 3'd3;
	localparam logic [2:0] ST_OFF   = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]                  state_q;
	logic [IW:0]                 idx_q;
	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	logic [zhh_pkg::ZONE_W-1:0]  zone_q;
	logic                        cls_on_q;
	logic                        blk_q;
	logic                        pend_vld_q;
	logic [IW-1:0]               pend_idx_q;
	logic                        strobe_q;
	logic [zhh_pkg::SLOT_W-1:0]  target_q;
	logic                        switch_on_q;
	logic                        last_q;

	logic          accept;
	logic          in_range;
	logic          ent_ok;
	logic          r_lo;
	logic          r_hi;
	logic [IW-1:0] slot_idx;
	logic          scanning;
	logic          scan_end;
	logic          hit_zone;
	logic          hit_on;
	logic          hit_off;
	logic          hit_blk;
	logic          scan_hit;

	assign accept   = start && (state_q == ST_IDLE);
	assign in_range = 9'(slot) < 9'(MAX_NODES);
	assign slot_idx = IW'(slot);
	assign ent_ok   = in_range && chk_valid;
	assign r_lo     = reading < on_below;
	assign r_hi     = reading > off_above;

	assign chk_idx  = slot_idx;
	assign wr_idx   = slot_idx;
	assign wr_attr  = '{kind: is_sensor, zone: area};
	assign rd_idx   = (state_q == ST_IDLE) ? slot_idx : idx_q[IW-1:0];

	always_comb begin
		wr_stat.value = reading;
		if (req_type == zhh_pkg::REQ_READ) begin
			wr_stat.mode = zhh_pkg::MODE_NUM;
		end else if (req_type == zhh_pkg::REQ_STATE && state_on) begin
			wr_stat.mode = zhh_pkg::MODE_ON;
		end else begin
			wr_stat.mode = zhh_pkg::MODE_OFF;
		end
	end

	always_comb begin
		wr = '0;
		if (accept) begin
			unique case (req_type)
				zhh_pkg::REQ_REG: begin
					wr.attr_we = in_range;
					wr.stat_we = in_range;
					wr.vset    = in_range;
				end
				zhh_pkg::REQ_STATE: begin
					wr.stat_we = ent_ok;
				end
				zhh_pkg::REQ_READ: begin
					wr.stat_we = ent_ok;
				end
				zhh_pkg::REQ_DISC: begin
					wr.vclr = ent_ok;
				end
				default: begin
					wr = '0;
				end
			endcase
		end
	end

	assign scanning = (state_q == ST_ON) || (state_q == ST_BLK) || (state_q == ST_OFF);
	assign scan_end = idx_q == (IW+1)'(MAX_NODES);

	assign hit_zone = vld_s1 && rd_valid && (rd_attr.zone == zone_q);
	assign hit_on   = hit_zone && (rd_attr.kind == zhh_pkg::KIND_HEATER)
		&& (rd_stat.mode == zhh_pkg::MODE_OFF);
	assign hit_off  = hit_zone && (rd_attr.kind == zhh_pkg::KIND_HEATER)
		&& (rd_stat.mode == zhh_pkg::MODE_ON);
	assign hit_blk  = hit_zone && (rd_stat.mode == zhh_pkg::MODE_NUM)
		&& ($signed(rd_stat.value) < on_below);
	assign scan_hit = ((state_q == ST_ON) && hit_on) || ((state_q == ST_OFF) && hit_off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			cls_on_q   <= 1'b0;
			blk_q      <= 1'b0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			vld_s1   <= scanning && !scan_end;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == zhh_pkg::REQ_REG && in_range && is_sensor) begin
						strobe_q <= 1'b1;
					end
					if (accept && req_type == zhh_pkg::REQ_READ && ent_ok && (r_lo || r_hi)) begin
						state_q    <= ST_ZONE;
						cls_on_q   <= r_lo;
						blk_q      <= 1'b0;
						pend_vld_q <= 1'b0;
					end
				end
				ST_ZONE: begin
					idx_q   <= '0;
					state_q <= cls_on_q ? ST_ON : ST_BLK;
				end
				ST_ON, ST_OFF: begin
					if (!scan_end) begin
						idx_q <= idx_q + {{IW{1'b0}}, 1'b1};
					end else begin
						state_q <= ST_FLUSH;
					end
					if (scan_hit) begin
						pend_vld_q <= 1'b1;
						if (pend_vld_q) begin
							strobe_q <= 1'b1;
						end
					end
				end
				ST_BLK: begin
					blk_q <= blk_q || hit_blk;
					if (!scan_end) begin
						idx_q <= idx_q + {{IW{1'b0}}, 1'b1};
					end else if (blk_q || hit_blk) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= '0;
						state_q <= ST_OFF;
					end
				end
				ST_FLUSH: begin
					strobe_q   <= pend_vld_q;
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload and scan pipeline data
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
		if (state_q == ST_ZONE) begin
			zone_q <= rd_attr.zone;
		end
		if (accept) begin
			target_q    <= slot;
			switch_on_q <= 1'b1;
			last_q      <= 1'b1;
		end else if (state_q == ST_FLUSH) begin
			target_q    <= zhh_pkg::SLOT_W'(pend_idx_q);
			switch_on_q <= cls_on_q;
			last_q      <= 1'b1;
		end else if (scan_hit) begin
			target_q    <= zhh_pkg::SLOT_W'(pend_idx_q);
			switch_on_q <= cls_on_q;
			last_q      <= 1'b0;
		end
		if (scan_hit) begin
			pend_idx_q <= idx_s1;
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign strobe      = strobe_q;
	assign target_slot = target_q;
	assign switch_on   = switch_on_q;
	assign last        = last_q;

endmodule

### rtl/core/zone_heating_hysteresis_table_unit.sv
// Top level: threshold registers, sequencer and entry table.
// Register, state report, disconnect and a reading that crosses no threshold never raise busy;
// a sensor register gives its switch-on beat the cycle after start. A crossing reading of a
// valid slot holds busy for one zone read, then one or two slot-order scans of one entry a
// cycle. At most one beat a cycle, the final one in the same cycle that busy falls; results
// cannot be stalled. Reset clears valid bits, thresholds 32 and 34.
module zone_heating_hysteresis_table_unit #(
	parameter int MAX_NODES = zhh_pkg::MAX_NODES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             req_type,
	input  logic [zhh_pkg::SLOT_W-1:0]             slot,
	input  logic                                   is_sensor,
	input  logic [zhh_pkg::ZONE_W-1:0]             area,
	input  logic                                   state_on,
	input  logic signed [zhh_pkg::TEMP_W-1:0]      reading,
	output logic                                   strobe,
	output logic [zhh_pkg::SLOT_W-1:0]             target_slot,
	output logic                                   switch_on,
	output logic                                   last,
	input  logic                                   cfg_we,
	input  logic [zhh_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [zhh_pkg::TEMP_W-1:0]             cfg_data
);

	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	logic signed [zhh_pkg::TEMP_W-1:0] on_below_q;
	logic signed [zhh_pkg::TEMP_W-1:0] off_above_q;

	zhh_pkg::tbl_wr_t wr;
	zhh_pkg::attr_t   wr_attr;
	zhh_pkg::stat_t   wr_stat;
	zhh_pkg::attr_t   rd_attr;
	zhh_pkg::stat_t   rd_stat;
	logic [IW-1:0]    wr_idx;
	logic [IW-1:0]    rd_idx;
	logic [IW-1:0]    chk_idx;
	logic             rd_valid;
	logic             chk_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_below_q  <= zhh_pkg::ON_BELOW_RST;
			off_above_q <= zhh_pkg::OFF_ABOVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				zhh_pkg::REG_ON_BELOW:  on_below_q  <= cfg_data;
				zhh_pkg::REG_OFF_ABOVE: off_above_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	zhh_seq #(
		.MAX_NODES(MAX_NODES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.slot       (slot),
		.is_sensor  (is_sensor),
		.area       (area),
		.state_on   (state_on),
		.reading    (reading),
		.on_below   (on_below_q),
		.off_above  (off_above_q),
		.wr         (wr),
		.wr_idx     (wr_idx),
		.wr_attr    (wr_attr),
		.wr_stat    (wr_stat),
		.rd_idx     (rd_idx),
		.chk_idx    (chk_idx),
		.rd_attr    (rd_attr),
		.rd_stat    (rd_stat),
		.rd_valid   (rd_valid),
		.chk_valid  (chk_valid),
		.busy       (busy),
		.strobe     (strobe),
		.target_slot(target_slot),
		.switch_on  (switch_on),
		.last       (last)
	);

	zhh_table #(
		.MAX_NODES(MAX_NODES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_idx   (wr_idx),
		.wr_attr  (wr_attr),
		.wr_stat  (wr_stat),
		.rd_idx   (rd_idx),
		.chk_idx  (chk_idx),
		.rd_attr  (rd_attr),
		.rd_stat  (rd_stat),
		.rd_valid (rd_valid),
		.chk_valid(chk_valid)
	);

	// a beat that is not the final one always has more of the same scan behind it
	a_nonlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final beat while idle");

	a_rise_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !strobe)
		else $error("beat on the cycle a scan starts");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (9'(target_slot) < 9'(MAX_NODES)))
		else $error("beat for a slot beyond the table");

endmodule
